// File: rtl/hts_pkg.sv
package hts_pkg;

    // number of channels with their own state
    localparam int CHANNELS = 4;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field widths
    localparam int CH_W    = 2;
    localparam int LEVEL_W = 16;
    localparam int STATE_W = 2;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESCAN = 1'b1;

    // level state codes
    localparam logic [STATE_W-1:0] LVL_CLEAR   = 2'd0;
    localparam logic [STATE_W-1:0] LVL_SET     = 2'd1;
    localparam logic [STATE_W-1:0] LVL_UNKNOWN = 2'd2;

    // register indexes (word address)
    localparam logic [1:0] REG_SET_LEVEL    = 2'd0;
    localparam logic [1:0] REG_CLEAR_LEVEL  = 2'd1;
    localparam logic [1:0] REG_SETTLE_DELAY = 2'd2;

    // register reset values
    localparam logic [LEVEL_W-1:0] SET_LEVEL_RST    = 16'd11000;
    localparam logic [LEVEL_W-1:0] CLEAR_LEVEL_RST  = 16'd11500;
    localparam logic [LEVEL_W-1:0] SETTLE_DELAY_RST = 16'd10;

    typedef struct packed {
        logic               opcode;
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] publish_channel;
        logic            flag_level;
        logic            from_rescan;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] set_level;
        logic [LEVEL_W-1:0] clear_level;
        logic [LEVEL_W-1:0] settle_delay;
    } t_cfg;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

// File: rtl/hts_cfg_regs.sv
module hts_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hts_pkg::APB_AW-1:0] paddr,
    input  logic [hts_pkg::APB_DW-1:0] pwdata,
    output logic [hts_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output hts_pkg::t_cfg             o_cfg
);

    logic [hts_pkg::LEVEL_W-1:0] r_set_level;
    logic [hts_pkg::LEVEL_W-1:0] r_clear_level;
    logic [hts_pkg::LEVEL_W-1:0] r_settle_delay;
    logic                        wr_en;
    logic [1:0]                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes, unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_level    <= hts_pkg::SET_LEVEL_RST;
            r_clear_level  <= hts_pkg::CLEAR_LEVEL_RST;
            r_settle_delay <= hts_pkg::SETTLE_DELAY_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                hts_pkg::REG_SET_LEVEL:    r_set_level    <= pwdata[hts_pkg::LEVEL_W-1:0];
                hts_pkg::REG_CLEAR_LEVEL:  r_clear_level  <= pwdata[hts_pkg::LEVEL_W-1:0];
                hts_pkg::REG_SETTLE_DELAY: r_settle_delay <= pwdata[hts_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            hts_pkg::REG_SET_LEVEL:    prdata = hts_pkg::APB_DW'(r_set_level);
            hts_pkg::REG_CLEAR_LEVEL:  prdata = hts_pkg::APB_DW'(r_clear_level);
            hts_pkg::REG_SETTLE_DELAY: prdata = hts_pkg::APB_DW'(r_settle_delay);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.set_level    = r_set_level;
    assign o_cfg.clear_level  = r_clear_level;
    assign o_cfg.settle_delay = r_settle_delay;

endmodule

// File: rtl/hts_chan_core.sv
module hts_chan_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  hts_pkg::t_in_item i_item,
    input  hts_pkg::t_cfg     i_cfg,
    output hts_pkg::t_result  o_result
);

    logic [hts_pkg::STATE_W-1:0] r_level [hts_pkg::CHANNELS];
    logic [hts_pkg::LEVEL_W-1:0] r_timer [hts_pkg::CHANNELS];
    logic                        r_pub   [hts_pkg::CHANNELS];

    logic [hts_pkg::CH_IDX_W-1:0] ch_idx;
    logic                         in_range;
    logic [hts_pkg::STATE_W-1:0]  cur_level;
    logic [hts_pkg::LEVEL_W-1:0]  cur_timer;
    logic [hts_pkg::LEVEL_W-1:0]  thr;
    logic                         below;
    logic [hts_pkg::STATE_W-1:0]  n_level;
    logic [hts_pkg::LEVEL_W-1:0]  n_timer;
    logic                         n_pub;
    logic                         emit;
    logic                         emit_flag;

    assign in_range  = int'(i_item.channel) < hts_pkg::CHANNELS;
    assign ch_idx    = hts_pkg::CH_IDX_W'(i_item.channel);
    assign cur_level = r_level[ch_idx];
    assign cur_timer = r_timer[ch_idx];

    // threshold pick and compare
    assign thr   = (cur_level != hts_pkg::LVL_CLEAR) ? i_cfg.clear_level : i_cfg.set_level;
    assign below = i_item.sample_value < thr;

    // next channel state and publication
    always_comb begin
        n_level   = cur_level;
        n_timer   = cur_timer;
        n_pub     = r_pub[ch_idx];
        emit      = 1'b0;
        emit_flag = r_pub[ch_idx];
        if (i_item.opcode == hts_pkg::OP_RESCAN) begin
            n_timer = '0;
            emit    = 1'b1;
        end else if (cur_level != {1'b0, below}) begin
            n_level = {1'b0, below};
            n_timer = i_cfg.settle_delay;
            if (i_cfg.settle_delay == '0) begin
                emit      = 1'b1;
                emit_flag = below;
                n_pub     = below;
            end
        end else if (cur_timer != '0) begin
            n_timer = cur_timer - 16'd1;
            if (cur_timer == 16'd1) begin
                emit      = 1'b1;
                emit_flag = below;
                n_pub     = below;
            end
        end
    end

    // per-channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hts_pkg::CHANNELS; i++) begin
                r_level[i] <= hts_pkg::LVL_UNKNOWN;
                r_timer[i] <= '0;
                r_pub[i]   <= 1'b0;
            end
        end else if (i_fire && in_range) begin
            r_level[ch_idx] <= n_level;
            r_timer[ch_idx] <= n_timer;
            r_pub[ch_idx]   <= n_pub;
        end
    end

    assign o_result.valid                = emit && in_range;
    assign o_result.item.publish_channel = i_item.channel;
    assign o_result.item.flag_level      = emit_flag;
    assign o_result.item.from_rescan     = (i_item.opcode == hts_pkg::OP_RESCAN);

endmodule

// File: rtl/hysteresis_threshold_scanner_unit.sv
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
// cfg       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one transaction per cycle sustained while results are taken; the accepting edge loads the
// input register, and a free or emptying result slot lets it move on into the result register
// synchronous active-low reset clears valids, channel states and configuration registers
// a stalled result holds in the result register; the input register still takes
// one more transaction, then o_in_ready drops until the result is taken
module hysteresis_threshold_scanner_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  hts_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output hts_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hts_pkg::APB_AW-1:0] paddr,
    input  logic [hts_pkg::APB_DW-1:0] pwdata,
    output logic [hts_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    logic               r_in_valid;
    hts_pkg::t_in_item  r_in;
    logic               r_out_valid;
    hts_pkg::t_out_item r_out;
    logic               fire;
    hts_pkg::t_cfg      cfg;
    hts_pkg::t_result   result;

    // configuration registers
    hts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the held transaction moves on when the result slot is free or emptying
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // channel state and decision
    hts_chan_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.valid) begin
            r_out <= result.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // full input register behind a stalled result blocks new transactions
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are stalled");

    // an in-range rescan always publishes, marked as rescan
    a_rescan_publishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.opcode == hts_pkg::OP_RESCAN
         && int'(r_in.channel) < hts_pkg::CHANNELS)
        |=> (o_out_valid && o_out_data.from_rescan))
        else $error("rescan transaction gave no rescan result");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_out_valid && !r_in_valid))
        else $error("valid state survived reset");

endmodule
